[hdl/sts_pkg.sv]
// shared types and constants for the sphere triangle subdivider
// no dependencies
`default_nettype none

package sts_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_AXES        = 3;

  // pipeline depth of sts_norm: magnitude, square, sum, root steps,
  // divide setup, quotient steps, sign
  function automatic int norm_lat(input int w);
    return 2 * w + 4;
  endfunction

  typedef enum logic [3:0] {
    TRI_FIRST  = 4'b0001,
    TRI_SECOND = 4'b0010,
    TRI_THIRD  = 4'b0100,
    TRI_CENTER = 4'b1000
  } tri_sel_t;

endpackage

`default_nettype wire

[hdl/sts_if.sv]
// valid/ready channel interfaces for triangle input and child triangle output
// depends on nothing; coordinate width is a parameter
`default_nettype none

interface sts_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] first_x;
  logic signed [W-1:0] first_y;
  logic signed [W-1:0] first_z;
  logic signed [W-1:0] second_x;
  logic signed [W-1:0] second_y;
  logic signed [W-1:0] second_z;
  logic signed [W-1:0] third_x;
  logic signed [W-1:0] third_y;
  logic signed [W-1:0] third_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  third_x, third_y, third_z, input ready);
  modport sink   (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  third_x, third_y, third_z, output ready);
endinterface

interface sts_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_first_x;
  logic signed [W-1:0] out_first_y;
  logic signed [W-1:0] out_first_z;
  logic signed [W-1:0] out_second_x;
  logic signed [W-1:0] out_second_y;
  logic signed [W-1:0] out_second_z;
  logic signed [W-1:0] out_third_x;
  logic signed [W-1:0] out_third_y;
  logic signed [W-1:0] out_third_z;
  logic                last_of_four;

  modport source (output valid, out_first_x, out_first_y, out_first_z, out_second_x,
                  out_second_y, out_second_z, out_third_x, out_third_y, out_third_z,
                  last_of_four, input ready);
  modport sink   (input valid, out_first_x, out_first_y, out_first_z, out_second_x,
                  out_second_y, out_second_z, out_third_x, out_third_y, out_third_z,
                  last_of_four, output ready);
endinterface

`default_nettype wire

[hdl/sphere_triangle_subdivider_core.sv]
// top level of the sphere triangle subdivider: midpoints, normalizers, output sequencer
// depends on sts_pkg, sts_in_if, sts_out_if and sts_norm
`default_nettype none

// Splits one unit-sphere triangle (signed Q1.(W-2) coordinates) into four child
// triangles, sent in the order (first,ab,ca), (second,bc,ab), (third,ca,bc),
// (ab,bc,ca), the last one marked by last_of_four. Edge midpoints are pushed
// back onto the sphere by a pipelined square root and divider, one bit per
// stage. The single result channel sends one child per cycle while the output
// is ready. While the sequencer is busy and a finished triangle waits at the
// pipeline's end, a new triangle is taken only as the fourth child leaves, so
// a stall on the output freezes the pipeline; until a finished triangle waits
// there, bubbles ahead of it still close up.
module sphere_triangle_subdivider_core #(
  parameter int COORD_WIDTH = sts_pkg::COORD_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  sts_in_if.sink    in_tri,
  sts_out_if.source out_tri
);
  import sts_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int NLAT = norm_lat(COORD_WIDTH);
  localparam logic signed [W-1:0] ONE     = W'(1) << (W - 2);
  localparam logic signed [W-1:0] NEG_ONE = -ONE;

  logic     en;
  logic     load;
  logic     out_fire;
  logic     ov_r;
  tri_sel_t beat_r;

  // vertex delay line and valid bits, aligned with the normalizers
  logic [2:0][2:0][W-1:0] vx_r  [NLAT+1];
  logic                   val_r [NLAT+1];
  logic [2:0][2:0][W-1:0] vin;

  assign vin[0] = {in_tri.first_z,  in_tri.first_y,  in_tri.first_x};
  assign vin[1] = {in_tri.second_z, in_tri.second_y, in_tri.second_x};
  assign vin[2] = {in_tri.third_z,  in_tri.third_y,  in_tri.third_x};

  assign in_tri.ready = en;

  // floor of half the sum per coordinate
  logic [2:0][2:0][W-1:0] mid_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          mid_r[e][i] <= W'(({vin[e][i][W-1], vin[e][i]}
                             + {vin[(e+1)%3][i][W-1], vin[(e+1)%3][i]}) >> 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NLAT; k++) begin
        val_r[k] <= 1'b0;
      end
    end else if (en) begin
      val_r[0] <= in_tri.valid;
      for (int k = 1; k <= NLAT; k++) begin
        val_r[k] <= val_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= vin;
      for (int k = 1; k <= NLAT; k++) begin
        vx_r[k] <= vx_r[k-1];
      end
    end
  end

  // mid_r[0] is ab, [1] is bc, [2] is ca
  logic [2:0][2:0][W-1:0] unit;

  for (genvar e = 0; e < 3; e++) begin : g_norm
    sts_norm #(.W(W)) u_norm (
      .clk    (clk),
      .en     (en),
      .mid_i  (mid_r[e]),
      .unit_o (unit[e])
    );
  end

  // hold register and child sequencer
  logic [2:0][2:0][W-1:0] hv_r;
  logic [2:0][2:0][W-1:0] hm_r;

  assign out_fire = ov_r && out_tri.ready;
  assign en       = !val_r[NLAT] || !ov_r || (out_tri.ready && beat_r == TRI_CENTER);
  assign load     = en && val_r[NLAT];

  always_ff @(posedge clk) begin
    if (load) begin
      hm_r <= unit;
      for (int v = 0; v < 3; v++) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if ($signed(vx_r[NLAT][v][i]) > ONE) begin
            hv_r[v][i] <= ONE;
          end else if ($signed(vx_r[NLAT][v][i]) < NEG_ONE) begin
            hv_r[v][i] <= NEG_ONE;
          end else begin
            hv_r[v][i] <= vx_r[NLAT][v][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      beat_r <= TRI_FIRST;
    end else if (load) begin
      ov_r   <= 1'b1;
      beat_r <= TRI_FIRST;
    end else if (out_fire) begin
      unique case (beat_r)
        TRI_FIRST:  beat_r <= TRI_SECOND;
        TRI_SECOND: beat_r <= TRI_THIRD;
        TRI_THIRD:  beat_r <= TRI_CENTER;
        TRI_CENTER: ov_r   <= 1'b0;
        default:    beat_r <= TRI_FIRST;
      endcase
    end
  end

  logic [2:0][W-1:0] p0;
  logic [2:0][W-1:0] p1;
  logic [2:0][W-1:0] p2;

  always_comb begin
    unique case (beat_r)
      TRI_FIRST:  begin p0 = hv_r[0]; p1 = hm_r[0]; p2 = hm_r[2]; end
      TRI_SECOND: begin p0 = hv_r[1]; p1 = hm_r[1]; p2 = hm_r[0]; end
      TRI_THIRD:  begin p0 = hv_r[2]; p1 = hm_r[2]; p2 = hm_r[1]; end
      TRI_CENTER: begin p0 = hm_r[0]; p1 = hm_r[1]; p2 = hm_r[2]; end
      default:    begin p0 = hv_r[0]; p1 = hm_r[0]; p2 = hm_r[2]; end
    endcase
  end

  assign out_tri.valid        = ov_r;
  assign out_tri.out_first_x  = p0[0];
  assign out_tri.out_first_y  = p0[1];
  assign out_tri.out_first_z  = p0[2];
  assign out_tri.out_second_x = p1[0];
  assign out_tri.out_second_y = p1[1];
  assign out_tri.out_second_z = p1[2];
  assign out_tri.out_third_x  = p2[0];
  assign out_tri.out_third_y  = p2[1];
  assign out_tri.out_third_z  = p2[2];
  assign out_tri.last_of_four = (beat_r == TRI_CENTER);

  // pipeline only stalls behind a busy sequencer
  assert property (@(posedge clk) disable iff (!rst_n)
    val_r[NLAT] && !en |-> ov_r)
    else $error("pipeline stalled with idle sequencer");

  // a held child keeps its position
  assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tri.ready |=> ov_r && $stable(beat_r))
    else $error("child triangle lost under backpressure");

  // sequencer drains after the fourth child with nothing behind it
  assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && beat_r == TRI_CENTER && out_tri.ready && !val_r[NLAT] |=> !ov_r)
    else $error("sequencer repeated a triangle set");

  // a new set always starts from the first child
  assert property (@(posedge clk) disable iff (!rst_n)
    load |=> ov_r && beat_r == TRI_FIRST)
    else $error("new set did not start at first child");

endmodule

`default_nettype wire

[hdl/sts_norm.sv]
// pipelined vector normalizer: squares, integer square root, rounded divide
// depends on sts_pkg; advances only when en is high
`default_nettype none

module sts_norm #(
  parameter int W = sts_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0][W-1:0]   mid_i,
  output logic [2:0][W-1:0]   unit_o
);
  import sts_pkg::*;

  localparam int SW = 2 * W;
  localparam int NW = 2 * W - 1;
  localparam int QW = W - 1;

  // magnitude and sign
  logic [2:0][W-1:0] mag_a_r;
  logic [2:0]        neg_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        neg_a_r[i] <= mid_i[i][W-1];
        mag_a_r[i] <= mid_i[i][W-1] ? (~mid_i[i] + 1'b1) : mid_i[i];
      end
    end
  end

  // squares
  logic [2:0][SW-1:0] sq_b_r;
  logic [2:0][W-1:0]  mag_b_r;
  logic [2:0]         neg_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        sq_b_r[i] <= mag_a_r[i] * mag_a_r[i];
      end
      mag_b_r <= mag_a_r;
      neg_b_r <= neg_a_r;
    end
  end

  // sum of squares
  logic [SW+1:0]     sum_c;
  logic [SW-1:0]     s_c_r;
  logic [2:0][W-1:0] mag_c_r;
  logic [2:0]        neg_c_r;

  assign sum_c = {2'b00, sq_b_r[0]} + {2'b00, sq_b_r[1]} + {2'b00, sq_b_r[2]};

  always_ff @(posedge clk) begin
    if (en) begin
      s_c_r   <= sum_c[SW-1:0];
      mag_c_r <= mag_b_r;
      neg_c_r <= neg_b_r;
    end
  end

  // integer square root, one result bit per stage
  logic [SW-1:0]     sn_r   [W];
  logic [SW-1:0]     sr_r   [W];
  logic [2:0][W-1:0] smag_r [W];
  logic [2:0]        sneg_r [W];

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * k);
    logic [SW-1:0]     n_src;
    logic [SW-1:0]     r_src;
    logic [SW-1:0]     trial;
    logic [2:0][W-1:0] m_src;
    logic [2:0]        g_src;

    if (k == 0) begin : g_first
      assign n_src = s_c_r;
      assign r_src = '0;
      assign m_src = mag_c_r;
      assign g_src = neg_c_r;
    end else begin : g_next
      assign n_src = sn_r[k-1];
      assign r_src = sr_r[k-1];
      assign m_src = smag_r[k-1];
      assign g_src = sneg_r[k-1];
    end

    assign trial = r_src + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_src >= trial) begin
          sn_r[k] <= n_src - trial;
          sr_r[k] <= (r_src >> 1) + BIT;
        end else begin
          sn_r[k] <= n_src;
          sr_r[k] <= r_src >> 1;
        end
        smag_r[k] <= m_src;
        sneg_r[k] <= g_src;
      end
    end
  end

  // divide setup: numerator 2*mag*one + len, divisor 2*len
  logic [W-1:0]       len;
  logic [2:0][NW-1:0] num_c;

  logic [2:0][NW-1:0] dn_r   [QW+1];
  logic [2:0][W:0]    dr_r   [QW+1];
  logic [2:0][QW-1:0] dq_r   [QW+1];
  logic [W:0]         dd_r   [QW+1];
  logic               dz_r   [QW+1];
  logic [2:0]         dneg_r [QW+1];

  assign len = sr_r[W-1][W-1:0];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      num_c[i] = (NW'(smag_r[W-1][i]) << (W - 1)) + NW'(len);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        dn_r[0][i] <= num_c[i];
        dr_r[0][i] <= {1'b0, num_c[i][NW-1:W-1]};
        dq_r[0][i] <= '0;
      end
      dd_r[0]   <= {len, 1'b0};
      dz_r[0]   <= (len == '0);
      dneg_r[0] <= sneg_r[W-1];
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [2:0][W+1:0] t;
    logic [2:0][W+1:0] diff;
    logic [2:0]        ge;

    always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
        t[i]    = {dr_r[j-1][i], dn_r[j-1][i][QW-j]};
        ge[i]   = t[i] >= {1'b0, dd_r[j-1]};
        diff[i] = t[i] - {1'b0, dd_r[j-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          dn_r[j][i] <= dn_r[j-1][i];
          dr_r[j][i] <= ge[i] ? diff[i][W:0] : t[i][W:0];
          dq_r[j][i] <= {dq_r[j-1][i][QW-2:0], ge[i]};
        end
        dd_r[j]   <= dd_r[j-1];
        dz_r[j]   <= dz_r[j-1];
        dneg_r[j] <= dneg_r[j-1];
      end
    end
  end

  // sign and zero-length case
  logic [2:0][W-1:0] unit_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (dz_r[QW]) begin
          unit_r[i] <= '0;
        end else if (dneg_r[QW][i]) begin
          unit_r[i] <= ~{1'b0, dq_r[QW][i]} + 1'b1;
        end else begin
          unit_r[i] <= {1'b0, dq_r[QW][i]};
        end
      end
    end
  end

  assign unit_o = unit_r;

endmodule

`default_nettype wire
